// ===== hw/rtl/ckt_pkg.sv =====
// Shared constants, types and codes for the counted key table.
package ckt_pkg;

  localparam int TABLE_SLOTS  = 16;
  localparam int MARKER_SLOTS = 4;
  localparam logic [7:0] EMPTY_KEY = 8'hFF;

  localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int MIDX_W   = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;
  localparam int SCAN_LEN = (TABLE_SLOTS > MARKER_SLOTS) ? TABLE_SLOTS : MARKER_SLOTS;
  localparam int IDX_W    = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
  localparam int USED_W   = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_MARK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Write and counter update controls from the sequencer to the storage.
  typedef struct packed {
    logic              key_we;
    logic              cnt_we;
    logic [SLOT_W-1:0] waddr;
    logic [7:0]        wkey;
    logic [7:0]        wcnt;
    logic              mark_we;
    logic [MIDX_W-1:0] maddr;
    logic [7:0]        mkey;
    logic              used_inc;
    logic              used_dec;
  } store_wr_t;

  // Read addresses from the sequencer.
  typedef struct packed {
    logic [IDX_W-1:0]  scan_idx;
    logic [SLOT_W-1:0] cnt_idx;
  } store_addr_t;

  // Read data back to the sequencer.
  typedef struct packed {
    logic [7:0]        scan_key;
    logic              scan_key_ok;
    logic [7:0]        scan_mark;
    logic              scan_mark_ok;
    logic [7:0]        hit_cnt;
    logic [USED_W-1:0] used;
  } store_rd_t;

endpackage

// ===== hw/rtl/ckt_ifs.sv =====
// Request and result channel interfaces of the counted key table.
interface ckt_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] item_key;
  logic [7:0] amount;
  logic [2:0] marker_slot;

  modport source (output valid, command, item_key, amount, marker_slot, input ready);
  modport sink (input valid, command, item_key, amount, marker_slot, output ready);
endinterface

interface ckt_res_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] held_count;
  logic       found;
  logic [3:0] slot_index;
  logic       is_marked;
  logic [4:0] used_slots;

  modport source (output valid, ok, held_count, found, slot_index, is_marked, used_slots,
                  input ready);
  modport sink (input valid, ok, held_count, found, slot_index, is_marked, used_slots,
                output ready);
endinterface

// ===== hw/rtl/ckt_store.sv =====
// Slot keys, slot counts, marker keys and the occupied-slot counter.
module ckt_store
  import ckt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_wr_t   wr,
  input  store_addr_t addr,
  output store_rd_t   rd
);

  logic [7:0]        slot_keys   [TABLE_SLOTS];
  logic [7:0]        slot_counts [TABLE_SLOTS];
  logic [7:0]        marker_keys [MARKER_SLOTS];
  logic [USED_W-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_keys[i] <= EMPTY_KEY;
      end
      for (int i = 0; i < MARKER_SLOTS; i++) begin
        marker_keys[i] <= EMPTY_KEY;
      end
      used <= '0;
    end else begin
      if (wr.key_we) begin
        slot_keys[wr.waddr] <= wr.wkey;
      end
      if (wr.mark_we) begin
        marker_keys[wr.maddr] <= wr.mkey;
      end
      if (wr.used_inc) begin
        used <= used + USED_W'(1);
      end else if (wr.used_dec) begin
        used <= used - USED_W'(1);
      end
    end
  end

  // A count is only ever read for an occupied slot, so it needs no reset.
  always_ff @(posedge clk) begin
    if (wr.cnt_we) begin
      slot_counts[wr.waddr] <= wr.wcnt;
    end
  end

  always_comb begin
    rd.scan_key_ok  = ({1'b0, addr.scan_idx} < (IDX_W + 1)'(TABLE_SLOTS));
    rd.scan_mark_ok = ({1'b0, addr.scan_idx} < (IDX_W + 1)'(MARKER_SLOTS));
    rd.scan_key     = slot_keys[addr.scan_idx[SLOT_W-1:0]];
    rd.scan_mark    = marker_keys[addr.scan_idx[MIDX_W-1:0]];
    rd.hit_cnt      = slot_counts[addr.cnt_idx];
    rd.used         = used;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_SLOTS))
    else $error("occupied count exceeds table size");

  a_used_one_way: assert property (@(posedge clk) disable iff (rst)
    !(wr.used_inc && wr.used_dec))
    else $error("occupied count asked to rise and fall at once");

  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    wr.used_inc |-> (wr.key_we && wr.wkey != EMPTY_KEY && slot_keys[wr.waddr] == EMPTY_KEY))
    else $error("slot filled that was not empty");

endmodule

// ===== hw/rtl/ckt_ctrl.sv =====
// Sequencer: scans the slots and marker slots one index at a time, then applies the command.
module ckt_ctrl
  import ckt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ckt_cmd_if.sink       cmd,
  ckt_res_if.source     res,
  output store_wr_t     wr,
  output store_addr_t   addr,
  input  store_rd_t     rd
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx;
  cmd_t              cmd_q;
  logic [7:0]        key_q;
  logic [7:0]        amt_q;
  logic [2:0]        mslot_q;
  logic              hit, efound, marked;
  logic [SLOT_W-1:0] hit_idx, empty_idx;

  logic              ok_n, found_n;
  logic [7:0]        cnt_n;
  logic [SLOT_W-1:0] sidx_n;

  logic              accept, reserved, amt_ok, mslot_ok, scan_last;
  logic              key_match, empty_match, mark_match;
  logic [7:0]        cnt_sum, cnt_diff;

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == ST_IDLE);
  assign res.valid   = (state == ST_DONE);
  assign reserved    = (key_q == EMPTY_KEY);
  assign amt_ok      = (amt_q != 8'd0);
  assign mslot_ok    = ({1'b0, cmd.marker_slot} < 4'(MARKER_SLOTS));
  assign scan_last   = (idx == IDX_W'(SCAN_LEN - 1));
  assign key_match   = rd.scan_key_ok && !reserved && (rd.scan_key == key_q);
  assign empty_match = rd.scan_key_ok && (rd.scan_key == EMPTY_KEY);
  assign mark_match  = rd.scan_mark_ok && !reserved && (rd.scan_mark == key_q);
  assign cnt_sum     = rd.hit_cnt + amt_q;
  assign cnt_diff    = rd.hit_cnt - amt_q;

  assign addr.scan_idx = idx;
  assign addr.cnt_idx  = hit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_q   <= cmd_t'(cmd.command);
          key_q   <= cmd.item_key;
          amt_q   <= cmd.amount;
          mslot_q <= cmd.marker_slot;
          idx     <= '0;
          hit     <= 1'b0;
          efound  <= 1'b0;
          marked  <= 1'b0;
          hit_idx <= '0;
        end
      end
      ST_SCAN: begin
        // First match wins, so the lowest slot is kept for both searches.
        if (key_match && !hit) begin
          hit     <= 1'b1;
          hit_idx <= idx[SLOT_W-1:0];
        end
        if (empty_match && !efound) begin
          efound    <= 1'b1;
          empty_idx <= idx[SLOT_W-1:0];
        end
        if (mark_match) begin
          marked <= 1'b1;
        end
        idx <= idx + IDX_W'(1);
      end
      ST_APPLY: begin
        res.ok         <= ok_n;
        res.found      <= found_n;
        res.held_count <= found_n ? cnt_n : 8'd0;
        res.slot_index <= found_n ? 4'(sidx_n) : 4'd0;
        res.is_marked  <= marked;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // The occupied count is written at the same edge that loads the result fields,
  // so it is shown straight from the store while the result waits.
  assign res.used_slots = 5'(rd.used);

  always_comb begin
    state_next  = state;
    wr          = '0;
    wr.mkey     = cmd.item_key;
    wr.maddr    = cmd.marker_slot[MIDX_W-1:0];
    wr.wkey     = key_q;
    wr.waddr    = hit_idx;
    wr.wcnt     = cnt_sum;
    ok_n        = 1'b0;
    found_n     = hit;
    cnt_n       = rd.hit_cnt;
    sidx_n      = hit_idx;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // Marker slots are written up front, so the scan sees the new marker.
          wr.mark_we = (cmd_t'(cmd.command) == CMD_MARK) && mslot_ok;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_DONE;
        unique case (cmd_q)
          CMD_ADD: begin
            if (!reserved && amt_ok) begin
              if (hit) begin
                wr.cnt_we = 1'b1;
                ok_n      = 1'b1;
                cnt_n     = cnt_sum;
              end else if (efound) begin
                wr.key_we   = 1'b1;
                wr.cnt_we   = 1'b1;
                wr.waddr    = empty_idx;
                wr.wcnt     = amt_q;
                wr.used_inc = 1'b1;
                ok_n        = 1'b1;
                found_n     = 1'b1;
                cnt_n       = amt_q;
                sidx_n      = empty_idx;
              end
            end
          end
          CMD_REMOVE: begin
            if (!reserved && amt_ok && hit && rd.hit_cnt >= amt_q) begin
              wr.cnt_we = 1'b1;
              wr.wcnt   = cnt_diff;
              ok_n      = 1'b1;
              cnt_n     = cnt_diff;
              if (cnt_diff == 8'd0) begin
                wr.key_we   = 1'b1;
                wr.wkey     = EMPTY_KEY;
                wr.used_dec = 1'b1;
                found_n     = 1'b0;
              end
            end
          end
          CMD_LOOKUP: begin
            ok_n = hit;
          end
          CMD_MARK: begin
            ok_n = ({1'b0, mslot_q} < 4'(MARKER_SLOTS));
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN && idx == '0))
    else $error("request accepted without starting a scan at slot zero");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_last) |=> state == ST_APPLY)
    else $error("scan did not hand over to apply after the last slot");

  a_found_after_ok_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && cmd_q == CMD_ADD && ok_n) |=> (res.valid && res.found))
    else $error("successful add reported the key as absent");

  a_reserved_never_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && reserved) |=> !hit)
    else $error("reserved key matched a slot");

endmodule

// ===== hw/rtl/counted_key_table.sv =====
// Top level of the counted key table: sequencer plus slot storage.
//
//   channel  dir  handshake     fields
//   cmd      in   valid/ready   command, item_key, amount, marker_slot
//   res      out  valid/ready   ok, held_count, found, slot_index, is_marked, used_slots
//
// Each request passes through these states from accept to result valid and back to ready:
// the accept in idle, a scan of one slot per cycle through the key, empty and marker
// comparators, the apply state, and the done state showing the result.
// The result holds until taken; ready stays low from accept until then.
// Synchronous reset empties every slot and marker at once; no clearing pass is needed.
module counted_key_table
  import ckt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ckt_cmd_if.sink   cmd,
  ckt_res_if.source res
);

  store_wr_t   wr;
  store_addr_t addr;
  store_rd_t   rd;

  ckt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .res  (res),
    .wr   (wr),
    .addr (addr),
    .rd   (rd)
  );

  ckt_store u_store (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .addr (addr),
    .rd   (rd)
  );

endmodule
